@@ src/space_saving_heavy_hitters_assert.svh @@
// Assertion macros for the space-saving heavy-hitter block.
// Depends on nothing; included by the top level only.
`ifndef SPACE_SAVING_HEAVY_HITTERS_ASSERT_SVH
`define SPACE_SAVING_HEAVY_HITTERS_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define SSH_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("space_saving_heavy_hitters: assertion failed");

// Next-cycle implication, disabled during reset
`define SSH_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("space_saving_heavy_hitters: assertion failed");

`else

`define SSH_ASSERT_IMP(name, clk, rst, ante, cons)
`define SSH_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

@@ src/ssh_pkg.sv @@
// Shared sizes, types and state codes of the space-saving heavy-hitter block.
// Depends on nothing; used by the channels, the cell, the control and the top.
package ssh_pkg;

   localparam int SLOTS      = 64;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 32;
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;

   // Search token that walks the row of cells, one cell a cycle
   typedef struct packed {
      key_type   key;
      logic      hit;
      slot_type  hit_slot;
      count_type hit_count;
      logic      min_set;
      slot_type  min_slot;
      count_type min_count;
      logic      min_valid;
      key_type   min_key;
   } probe_type;

   // Update broadcast to the row; only the addressed cell takes it
   typedef struct packed {
      logic      en;
      slot_type  slot;
      key_type   key;
      count_type count;
   } write_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

endpackage

@@ src/ssh_if.sv @@
// Valid/ready channels of the space-saving heavy-hitter block.
// Depends on ssh_pkg for the payload types.
interface ssh_req_if;
   import ssh_pkg::*;

   logic    valid;
   logic    ready;
   key_type key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface ssh_rsp_if;
   import ssh_pkg::*;

   logic      valid;
   logic      ready;
   slot_type  slot;
   count_type count_after;
   logic      was_hit;
   logic      evicted_valid;
   key_type   evicted_key;
   count_type evicted_count;

   modport source (output valid, output slot, output count_after, output was_hit,
                   output evicted_valid, output evicted_key, output evicted_count,
                   input ready);
   modport sink   (input valid, input slot, input count_after, input was_hit,
                   input evicted_valid, input evicted_key, input evicted_count,
                   output ready);
endinterface

@@ src/ssh_cell.sv @@
// One table slot: key, count and valid bit, plus one stage of the search row.
// Depends on ssh_pkg.
module ssh_cell (
   input  logic               clock,
   input  logic               reset,
   input  ssh_pkg::slot_type  index,
   input  ssh_pkg::probe_type probe_prev,
   input  ssh_pkg::write_type wr,
   output ssh_pkg::probe_type probe_next
);
   import ssh_pkg::*;

   key_type   key_ff,   key_in;
   count_type count_ff, count_in;
   logic      valid_ff, valid_in;
   probe_type probe_ff, probe_in;

   logic      take;

   // Take the update when it addresses this slot
   always_comb begin
      take     = wr.en && (wr.slot == index);
      key_in   = take ? wr.key : key_ff;
      count_in = take ? wr.count : count_ff;
      valid_in = take ? 1'b1 : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // Key store has no reset value; it is read only behind the valid bit
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // Fold this slot into the token: first match wins, strict minimum keeps the lower slot
   always_comb begin
      probe_in = probe_prev;
      if (valid_ff && !probe_prev.hit && (key_ff == probe_prev.key)) begin
         probe_in.hit       = 1'b1;
         probe_in.hit_slot  = index;
         probe_in.hit_count = count_ff;
      end
      if (!probe_prev.min_set || (count_ff < probe_prev.min_count)) begin
         probe_in.min_set   = 1'b1;
         probe_in.min_slot  = index;
         probe_in.min_count = count_ff;
         probe_in.min_valid = valid_ff;
         probe_in.min_key   = key_ff;
      end
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
   end

   assign probe_next = probe_ff;

endmodule

@@ src/ssh_ctrl.sv @@
// Sequencer of the heavy-hitter block: takes a key, times the walk through the
// row of cells, commits the update and holds the result beat. Depends on ssh_pkg, ssh_if.
module ssh_ctrl (
   input  logic               clock,
   input  logic               reset,
   ssh_req_if.sink            req_ch,
   ssh_rsp_if.source          rsp_ch,
   output ssh_pkg::probe_type seed,
   input  ssh_pkg::probe_type tail,
   output ssh_pkg::write_type wr
);
   import ssh_pkg::*;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   state_type state_ff, state_in;
   slot_type  cnt_ff,   cnt_in;
   key_type   key_ff,   key_in;

   logic      rsp_valid_ff, rsp_valid_in;
   slot_type  rsp_slot_ff;
   count_type rsp_count_ff;
   logic      rsp_hit_ff;
   logic      rsp_ev_valid_ff;
   key_type   rsp_ev_key_ff;
   count_type rsp_ev_count_ff;

   logic      accept;
   logic      fire;
   logic      res_hit;
   slot_type  res_slot;
   count_type res_count;
   logic      res_ev_valid;
   key_type   res_ev_key;
   count_type res_ev_count;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign fire         = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      key_in   = accept ? req_ch.key : key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + slot_type'(1);
            if (cnt_ff == slot_type'(SLOTS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // Launch an empty token carrying the held key into the first cell
   always_comb begin
      seed           = '0;
      seed.key       = key_ff;
      seed.hit       = 1'b0;
      seed.min_set   = 1'b0;
   end

   // Resolve the token that left the last cell
   always_comb begin
      res_hit      = tail.hit;
      res_slot     = res_hit ? tail.hit_slot : tail.min_slot;
      res_count    = sat_inc(res_hit ? tail.hit_count : tail.min_count);
      res_ev_valid = !res_hit && tail.min_valid;
      res_ev_key   = res_ev_valid ? tail.min_key : '0;
      res_ev_count = res_hit ? '0 : tail.min_count;
   end

   // Write the chosen slot back in the cycle the result beat is loaded
   always_comb begin
      wr.en    = fire;
      wr.slot  = res_slot;
      wr.key   = key_ff;
      wr.count = res_count;
   end

   // Hold the result beat until the sink takes it
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_slot_ff     <= res_slot;
         rsp_count_ff    <= res_count;
         rsp_hit_ff      <= res_hit;
         rsp_ev_valid_ff <= res_ev_valid;
         rsp_ev_key_ff   <= res_ev_key;
         rsp_ev_count_ff <= res_ev_count;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.count_after   = rsp_count_ff;
   assign rsp_ch.was_hit       = rsp_hit_ff;
   assign rsp_ch.evicted_valid = rsp_ev_valid_ff;
   assign rsp_ch.evicted_key   = rsp_ev_key_ff;
   assign rsp_ch.evicted_count = rsp_ev_count_ff;

endmodule

@@ src/space_saving_heavy_hitters.sv @@
// Space-saving heavy-hitter counter over a table of SLOTS (64) keys with saturating counts.
// Each accepted key walks a row of SLOTS cells, one cell per cycle; every cell compares the
// key against its own entry and folds its count into a running minimum, so the row yields the
// first matching slot or, on a miss, the lowest slot of smallest count. The item then
// commits, which writes the slot and loads the result beat; the commit waits while an
// earlier result beat has not been taken. A new key is taken only once the previous
// item has committed, even while its result beat waits. No clearing pass is needed
// after reset.
`include "space_saving_heavy_hitters_assert.svh"

module space_saving_heavy_hitters (
   input logic       clock,
   input logic       reset,
   ssh_req_if.sink   req_ch,
   ssh_rsp_if.source rsp_ch
);
   import ssh_pkg::*;

   probe_type chain [SLOTS+1];
   write_type wr;

   ssh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .seed   (chain[0]),
      .tail   (chain[SLOTS]),
      .wr     (wr)
   );

   // Row of slot cells, each handing the token to its neighbor
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ssh_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .index      (slot_type'(i)),
         .probe_prev (chain[i]),
         .wr         (wr),
         .probe_next (chain[i+1])
      );
   end

   // Drop ready after a key is taken
   `SSH_ASSERT_NXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A hit never reports an eviction
   `SSH_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_ch.valid && rsp_ch.was_hit, !rsp_ch.evicted_valid && (rsp_ch.evicted_count == '0))
   // Every reported count is at least one
   `SSH_ASSERT_IMP(a_count_nonzero, clock, reset, rsp_ch.valid, rsp_ch.count_after != '0)
   // A live key is never evicted from an empty-count slot
   `SSH_ASSERT_IMP(a_evict_live, clock, reset, rsp_ch.valid && rsp_ch.evicted_valid, rsp_ch.evicted_count != '0)

endmodule
